// File: hw/rtl/tst_pkg.sv
// shared types, constants and helpers of the transaction slot tracker
`default_nettype none

package tst_pkg;

    // default table size
    localparam int SLOTS_DEFAULT = 8;
    // a scan frees at most this many slots, one more result closes it
    localparam int MAX_TIMEOUTS  = 8;

    localparam int SEQ_W   = 8;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 31;
    localparam int ID_W    = 16;
    localparam int KIND_W  = 3;
    localparam int SLOT_W  = 3;

    localparam logic [DELAY_W-1:0] TIMEOUT_RESET = 31'd20000;

    // item types
    typedef enum logic [1:0] {
        REQ_ISSUE    = 2'd0,
        REQ_RESPONSE = 2'd1,
        REQ_TICK     = 2'd2
    } t_req;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED   = 3'd0,
        KIND_REFUSED    = 3'd1,
        KIND_DELIVERED  = 3'd2,
        KIND_DISCARDED  = 3'd3,
        KIND_TIMED_OUT  = 3'd4,
        KIND_NEXT_DELAY = 3'd5,
        KIND_NONE       = 3'd6
    } t_kind;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_CHECK = 2'd2,
        ST_FINAL = 2'd3
    } t_state;

    // one slot record as held in the table memory
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   cluster;
        logic [ID_W-1:0]   context_tag;
    } t_entry;

    // one result beat
    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic [SEQ_W-1:0]   seq;
        logic [ID_W-1:0]    tag;
        logic [ID_W-1:0]    cluster;
        logic               completed;
        logic [DELAY_W-1:0] delay;
        logic               last;
    } t_result;

    // index width for a table of n entries
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tst_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module tst_ram
    import tst_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [idx_w(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]          i_wdata,
    input  wire logic                      i_re,
    input  wire logic [idx_w(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tst_seq.sv
// slot sequencer: busy bits, sequence counter and the table walk
`default_nettype none

module tst_seq
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [TIME_W-1:0]         i_now,
    input  wire logic                      i_send_ok,
    input  wire logic                      i_wants_reply,
    input  wire logic [ID_W-1:0]           i_cluster_id,
    input  wire logic [ID_W-1:0]           i_context_tag,
    input  wire logic [SEQ_W-1:0]          i_resp_sequence,
    input  wire logic [DELAY_W-1:0]        i_timeout,
    output logic                           o_busy,
    output logic                           o_res_valid,
    output t_result                        o_res,
    output logic                           o_ram_we,
    output logic [idx_w(SLOTS)-1:0]        o_ram_waddr,
    output t_entry                         o_ram_wdata,
    output logic                           o_ram_re,
    output logic [idx_w(SLOTS)-1:0]        o_ram_raddr,
    input  t_entry                         i_ram_rdata
);

    localparam int IW = idx_w(SLOTS);
    localparam int NW = $clog2(MAX_TIMEOUTS + 1);

    t_state             r_state, n_state;
    logic [SLOTS-1:0]   r_busy, n_busy;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [IW-1:0]      r_idx, n_idx;
    t_req               r_type, n_type;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [SEQ_W-1:0]   r_rs, n_rs;
    logic [NW-1:0]      r_n, n_n;
    logic               r_have, n_have;
    logic [DELAY_W-1:0] r_best, n_best;

    logic               found;
    logic [IW-1:0]      free_idx;
    logic               last_idx;
    logic [TIME_W-1:0]  diff;
    logic               expired;
    logic [DELAY_W-1:0] remain;
    logic [IW+SLOT_W-1:0] free_wide;
    logic [IW+SLOT_W-1:0] cur_wide;

    // lowest free slot
    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign last_idx  = (r_idx == IW'(SLOTS - 1));
    assign free_wide = {{SLOT_W{1'b0}}, free_idx};
    assign cur_wide  = {{SLOT_W{1'b0}}, r_idx};

    // deadline check on the slot just read
    assign diff    = i_ram_rdata.deadline - r_now;
    assign expired = (diff == '0) || diff[TIME_W-1];
    assign remain  = expired ? '0 : diff[DELAY_W-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_seq   <= n_seq;
        end
    end

    // walk context
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_type <= n_type;
        r_now  <= n_now;
        r_rs   <= n_rs;
        r_n    <= n_n;
        r_have <= n_have;
        r_best <= n_best;
    end

    // next state and results
    always_comb begin
        n_state  = r_state;
        n_busy   = r_busy;
        n_seq    = r_seq;
        n_idx    = r_idx;
        n_type   = r_type;
        n_now    = r_now;
        n_rs     = r_rs;
        n_n      = r_n;
        n_have   = r_have;
        n_best   = r_best;

        o_res_valid = 1'b0;
        o_res       = '0;

        o_ram_we    = 1'b0;
        o_ram_waddr = free_idx;
        o_ram_wdata.seq         = {1'b0, r_seq[SEQ_W-2:0]};
        o_ram_wdata.deadline    = i_now + {1'b0, i_timeout};
        o_ram_wdata.cluster     = i_cluster_id;
        o_ram_wdata.context_tag = i_context_tag;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (t_req'(i_req_type))
                        REQ_ISSUE: begin
                            o_res_valid = 1'b1;
                            o_res.last  = 1'b1;
                            if (!found || !i_send_ok) begin
                                o_res.kind = KIND_REFUSED;
                            end else begin
                                o_res.kind      = KIND_ACCEPTED;
                                o_res.slot      = free_wide[SLOT_W-1:0];
                                o_res.seq       = {1'b0, r_seq[SEQ_W-2:0]};
                                o_res.tag       = i_context_tag;
                                o_res.cluster   = i_cluster_id;
                                o_res.completed = !i_wants_reply;
                                n_seq           = r_seq + 1'b1;
                                if (i_wants_reply) begin
                                    o_ram_we         = 1'b1;
                                    n_busy[free_idx] = 1'b1;
                                end
                            end
                        end
                        REQ_RESPONSE, REQ_TICK: begin
                            n_type  = t_req'(i_req_type);
                            n_now   = i_now;
                            n_rs    = i_resp_sequence;
                            n_idx   = '0;
                            n_n     = '0;
                            n_have  = 1'b0;
                            n_best  = '0;
                            n_state = ST_READ;
                        end
                        default: begin
                            // unknown item type is dropped
                        end
                    endcase
                end
            end

            ST_READ: begin
                // fetch held slots, skip free ones
                if (r_busy[r_idx]) begin
                    o_ram_re = 1'b1;
                    n_state  = ST_CHECK;
                end else if (last_idx) begin
                    n_state = ST_FINAL;
                end else begin
                    n_idx = IW'(r_idx + 1'b1);
                end
            end

            ST_CHECK: begin
                n_state = last_idx ? ST_FINAL : ST_READ;
                n_idx   = IW'(r_idx + 1'b1);
                if (r_type == REQ_RESPONSE) begin
                    // first held slot with matching sequence
                    if (i_ram_rdata.seq == r_rs) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_DELIVERED;
                        o_res.slot      = cur_wide[SLOT_W-1:0];
                        o_res.seq       = r_rs;
                        o_res.tag       = i_ram_rdata.context_tag;
                        o_res.cluster   = i_ram_rdata.cluster;
                        o_res.completed = !r_rs[SEQ_W-1];
                        o_res.last      = 1'b1;
                        if (!r_rs[SEQ_W-1]) begin
                            n_busy[r_idx] = 1'b0;
                        end
                        n_state = ST_IDLE;
                    end
                end else begin
                    // expire or fold into minimum delay
                    if (expired && (r_n < NW'(MAX_TIMEOUTS))) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_TIMED_OUT;
                        o_res.slot      = cur_wide[SLOT_W-1:0];
                        o_res.seq       = i_ram_rdata.seq;
                        o_res.tag       = i_ram_rdata.context_tag;
                        o_res.cluster   = i_ram_rdata.cluster;
                        o_res.completed = 1'b1;
                        n_busy[r_idx]   = 1'b0;
                        n_n             = r_n + 1'b1;
                    end else if (!r_have || (remain < r_best)) begin
                        n_best = remain;
                        n_have = 1'b1;
                    end
                end
            end

            ST_FINAL: begin
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                if (r_type == REQ_RESPONSE) begin
                    o_res.kind = KIND_DISCARDED;
                    o_res.seq  = r_rs;
                end else if (r_have) begin
                    o_res.kind  = KIND_NEXT_DELAY;
                    o_res.delay = r_best;
                end else begin
                    o_res.kind = KIND_NONE;
                end
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/transaction_slot_tracker_core.sv
// top level of the outstanding transaction slot tracker
//
// Usage: an item (request, response or tick) is taken at a clock edge with
// start high and busy low. Results come out one beat per cycle on the o_
// result ports, flagged by o_result_strobe; o_last marks the final beat of
// an item. The receiver cannot stall: each beat is shown for one cycle only.
// A request answers in the cycle after it is taken and busy stays low,
// so requests can follow back to back. Responses and ticks walk the slot
// table: each held slot is read from the slot memory, then compared, and each
// free slot is skipped; a closing beat follows the walk. Busy stays high for
// the walk and the closing beat, and the closing beat shows in the first cycle
// with busy low. A response ends early at its first match.
// Timeout register: written through i_cfg_valid/i_cfg_data, always ready;
// the user writes it only while the block is idle; the block does not check.
// Reset (synchronous, active low) frees all slots, clears the sequence
// counter and loads the default timeout of 20000 ticks; slot memory
// contents are left as they are, only busy slots are ever read.
`default_nettype none

module transaction_slot_tracker_core
    import tst_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [TIME_W-1:0]    i_now,
    input  wire logic                 i_send_ok,
    input  wire logic                 i_wants_reply,
    input  wire logic [ID_W-1:0]      i_cluster_id,
    input  wire logic [ID_W-1:0]      i_context_tag,
    input  wire logic [SEQ_W-1:0]     i_resp_sequence,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [DELAY_W-1:0]   i_cfg_data,
    output logic                      o_result_strobe,
    output logic [KIND_W-1:0]         o_result_kind,
    output logic [SLOT_W-1:0]         o_slot_index,
    output logic [SEQ_W-1:0]          o_sequence_id,
    output logic [ID_W-1:0]           o_tag_out,
    output logic [ID_W-1:0]           o_cluster_out,
    output logic                      o_completed,
    output logic [DELAY_W-1:0]        o_next_delay,
    output logic                      o_last
);

    localparam int IW = idx_w(SLOTS);

    logic [DELAY_W-1:0] r_timeout;
    logic               r_out_valid;
    t_result            r_out;

    logic               seq_busy;
    logic               res_valid;
    t_result            res;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [$bits(t_entry)-1:0] ram_rdata;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // slot table memory
    tst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    tst_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_req_type      (i_req_type),
        .i_now           (i_now),
        .i_send_ok       (i_send_ok),
        .i_wants_reply   (i_wants_reply),
        .i_cluster_id    (i_cluster_id),
        .i_context_tag   (i_context_tag),
        .i_resp_sequence (i_resp_sequence),
        .i_timeout       (r_timeout),
        .o_busy          (seq_busy),
        .o_res_valid     (res_valid),
        .o_res           (res),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (t_entry'(ram_rdata))
    );

    assign busy = seq_busy;

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_result_strobe = r_out_valid;
    assign o_result_kind   = r_out.kind;
    assign o_slot_index    = r_out.slot;
    assign o_sequence_id   = r_out.seq;
    assign o_tag_out       = r_out.tag;
    assign o_cluster_out   = r_out.cluster;
    assign o_completed     = r_out.completed;
    assign o_next_delay    = r_out.delay;
    assign o_last          = r_out.last;

endmodule

`default_nettype wire

// File: hw/rtl/tst_checker.sv
// port-level checks of the slot tracker and their binding to the top level
`default_nettype none

module tst_checker
    import tst_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [1:0]        i_req_type,
    input wire logic              o_result_strobe,
    input wire logic [KIND_W-1:0] o_result_kind,
    input wire logic [SLOT_W-1:0] o_slot_index,
    input wire logic [SEQ_W-1:0]  o_sequence_id,
    input wire logic              o_completed,
    input wire logic              o_last
);

    // a request answers with one final beat in the next cycle
    a_issue_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_ISSUE)) |=> (o_result_strobe && o_last))
        else $error("request not answered in the next cycle");

    // timeouts free the slot and never close the item
    a_timeout_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_result_kind == KIND_TIMED_OUT)) |-> (o_completed && !o_last))
        else $error("timeout beat malformed");

    // after a final beat, a new beat needs a newly taken item
    a_no_extra_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last) |=> (!o_result_strobe || $past(start && !busy)))
        else $error("beat without a taken item");

    // a refusal carries no slot or sequence
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_result_kind == KIND_REFUSED))
            |-> ((o_slot_index == '0) && (o_sequence_id == '0) && o_last))
        else $error("refusal beat carries data");

endmodule

bind transaction_slot_tracker_core tst_checker u_checker (.*);

`default_nettype wire
